// File: hdl/spike_cross_correlogram_unit_defines.svh
// assertion macros for the spike cross-correlogram unit
`ifndef SPIKE_CROSS_CORRELOGRAM_UNIT_DEFINES_SVH
`define SPIKE_CROSS_CORRELOGRAM_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCC_ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define SCC_ASSERT_NEXT(lbl, clk, a, b) \
   lbl: assert property (@(posedge clk) (a) |=> (b)) else $error("assertion failed");
`else
`define SCC_ASSERT_IMPL(lbl, clk, rst, a, b)
`define SCC_ASSERT_NEXT(lbl, clk, a, b)
`endif
`endif

// File: hdl/scc_pkg.sv
// shared types and constants of the spike cross-correlogram unit
package scc_pkg;
   localparam int MAX_UNITS     = 16;
   localparam int MAX_HALF_BINS = 31;
   localparam int WINDOW_DEPTH  = 64;
   localparam int TIME_BITS     = 40;
   localparam int NBINS_MAX     = 2 * MAX_HALF_BINS + 1;
   localparam int HIST_DEPTH    = MAX_UNITS * MAX_UNITS * NBINS_MAX;
   localparam int HIST_AW       = 14;
   localparam int WIN_AW        = 6;
   localparam int LAG_BITS      = 27;

   typedef enum logic [1:0] {
      FUNC_SPIKE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_UNIT = 2'd1,
      ST_BACKWARD = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_BIN_WIDTH  = 2'd0,
      CSR_HALF_BINS  = 2'd1,
      CSR_UNIT_COUNT = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_RESULT,
      KIND_SPIKE,
      KIND_READ,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      status_type             status;
      logic [TIME_BITS-1:0]   spike_time;
      logic [3:0]             unit;
      logic [HIST_AW-1:0]     read_index;
   } cmd_type;

   typedef struct packed {
      logic [19:0] width;
      logic [4:0]  half;
      logic [4:0]  units;
   } cfg_type;

   typedef struct packed {
      logic clearing;
      logic walking;
   } back_stat_type;
endpackage

// File: hdl/scc_front.sv
// front end: configuration registers, item checks and time ordering
module scc_front import scc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  logic [1:0]           req_func,
   input  logic [TIME_BITS-1:0] req_spike_time,
   input  logic [7:0]           req_unit_id,
   input  logic [HIST_AW-1:0]   req_read_index,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [19:0]          csr_wdata,
   output logic                 cmd_push,
   output cmd_type              cmd_data,
   output cfg_type              cfg
);
   logic [19:0]          bw_ff;
   logic [4:0]           half_ff;
   logic [4:0]           uc_ff;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [4:0]           uc_eff;
   logic                 unit_ok;

   always_comb begin
      if (uc_ff == 5'd0) uc_eff = 5'd1;
      else if (uc_ff > 5'(MAX_UNITS)) uc_eff = 5'(MAX_UNITS);
      else uc_eff = uc_ff;
      cfg.width = (bw_ff == 20'd0) ? 20'd1 : bw_ff;
      cfg.half  = half_ff;
      cfg.units = uc_eff;
   end

   assign unit_ok  = (req_unit_id != 8'd0) && (req_unit_id <= {3'd0, uc_eff});
   assign cmd_push = req_push && !req_full;

   always_comb begin
      cmd_data.kind       = KIND_RESULT;
      cmd_data.status     = ST_OK;
      cmd_data.spike_time = req_spike_time;
      cmd_data.unit       = 4'(req_unit_id - 8'd1);
      cmd_data.read_index = req_read_index;
      last_in             = last_ff;
      case (func_type'(req_func))
         FUNC_SPIKE: begin
            if (!unit_ok) cmd_data.status = ST_BAD_UNIT;
            else if (req_spike_time < last_ff) cmd_data.status = ST_BACKWARD;
            else begin
               cmd_data.kind = KIND_SPIKE;
               last_in       = req_spike_time;
            end
         end
         FUNC_READ:  cmd_data.kind = KIND_READ;
         FUNC_CLEAR: begin
            cmd_data.kind = KIND_CLEAR;
            last_in       = '0;
         end
         default:    cmd_data.kind = KIND_RESULT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff   <= 20'd1;
         half_ff <= 5'd0;
         uc_ff   <= 5'(MAX_UNITS);
         last_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_BIN_WIDTH:  bw_ff   <= csr_wdata;
               CSR_HALF_BINS:  half_ff <= csr_wdata[4:0];
               CSR_UNIT_COUNT: uc_ff   <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (cmd_push) last_ff <= last_in;
      end
   end
endmodule

// File: hdl/scc_queue.sv
// two-entry command queue between front and back end
module scc_queue import scc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_data
);
   cmd_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign full     = count_ff == 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_data = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// File: hdl/scc_back.sv
// back end: spike window, lag binning and histogram store
module scc_back import scc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   input  logic          rsp_pop,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [31:0]   rsp_bin_count,
   output logic [7:0]    rsp_pairs_added,
   output back_stat_type stat
);
   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_RDOUT, S_SETUP, S_EV_RD, S_EV_TEST, S_W_RD, S_W_LAG,
      S_W_DIV, S_W_IDX1, S_W_IDX2, S_W_HRD, S_W_HWR, S_DONE
   } state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] stamp;
      logic [3:0]           unit;
   } win_entry_type;

   logic [31:0]   hist_mem [HIST_DEPTH];
   win_entry_type win_mem  [WINDOW_DEPTH];
   logic [31:0]   hist_q_ff;
   win_entry_type win_q_ff;

   state_type            state_ff;
   logic                 rsp_valid_ff, reply_ff, rd_ok_ff, back_ff, fwd_ok_ff;
   logic [1:0]           status_ff;
   logic [31:0]          count_ff;
   logic [7:0]           added_ff;
   logic [TIME_BITS-1:0] t_ff;
   logic [3:0]           a_ff, b_ff;
   logic [25:0]          edge_ff;
   logic [WIN_AW:0]      fill_ff;
   logic [WIN_AW-1:0]    head_ff, k_ff;
   logic [LAG_BITS-1:0]  dt2_ff, rem_ff;
   logic [4:0]           quot_ff;
   logic [2:0]           step_ff;
   logic [7:0]           pair_ff;
   logic [HIST_AW-1:0]   haddr_ff, clr_ff;

   logic                 hist_we, win_we;
   logic [HIST_AW-1:0]   hist_waddr, hist_raddr;
   logic [31:0]          hist_wdata;
   logic [WIN_AW-1:0]    win_raddr;
   logic [TIME_BITS-1:0] lag;
   logic [TIME_BITS:0]   lag2;
   logic [LAG_BITS-1:0]  div_sh;
   logic [5:0]           nb, bin;
   logic [8:0]           pair_sum;
   logic [14:0]          idx_sum;
   logic [3:0]           first_u, second_u;

   assign nb       = {cfg.half, 1'b1};
   assign lag      = t_ff - win_q_ff.stamp;
   assign lag2     = {lag, 1'b0};
   assign div_sh   = LAG_BITS'({cfg.width, 1'b0}) << step_ff;
   assign bin      = back_ff ? 6'({1'b0, cfg.half} - {1'b0, quot_ff})
                             : 6'({1'b0, cfg.half} + {1'b0, quot_ff});
   assign first_u  = back_ff ? a_ff : b_ff;
   assign second_u = back_ff ? b_ff : a_ff;
   assign pair_sum = 9'(first_u * cfg.units) + 9'(second_u);
   assign idx_sum  = 15'(pair_ff * nb) + 15'(bin);

   assign cmd_pop         = state_ff == S_IDLE && cmd_valid && !rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_bin_count   = count_ff;
   assign rsp_pairs_added = added_ff;
   assign stat.clearing   = state_ff == S_CLR;
   assign stat.walking    = state_ff != S_CLR && state_ff != S_IDLE && state_ff != S_RDOUT;

   always_comb begin
      hist_we    = 1'b0;
      hist_waddr = haddr_ff;
      hist_wdata = (hist_q_ff == 32'hFFFF_FFFF) ? hist_q_ff : hist_q_ff + 32'd1;
      hist_raddr = haddr_ff;
      win_we     = state_ff == S_DONE;
      win_raddr  = head_ff - fill_ff[WIN_AW-1:0];
      case (state_ff)
         S_CLR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            hist_wdata = '0;
         end
         S_IDLE:  hist_raddr = cmd.read_index;
         S_W_RD:  win_raddr  = head_ff - WIN_AW'(1) - k_ff;
         S_W_HWR: hist_we    = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      hist_q_ff <= hist_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (win_we) win_mem[head_ff] <= '{stamp: t_ff, unit: a_ff};
      win_q_ff <= win_mem[win_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         reply_ff     <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         if (rsp_pop && rsp_valid_ff) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + HIST_AW'(1);
               if (clr_ff == HIST_AW'(HIST_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
                  if (reply_ff) begin
                     rsp_valid_ff <= 1'b1;
                     status_ff    <= ST_OK;
                     count_ff     <= '0;
                     added_ff     <= '0;
                  end
               end
            end
            S_IDLE: begin
               if (cmd_pop) begin
                  t_ff     <= cmd.spike_time;
                  a_ff     <= cmd.unit;
                  rd_ok_ff <= cmd.read_index < HIST_AW'(HIST_DEPTH);
                  count_ff <= '0;
                  added_ff <= '0;
                  case (cmd.kind)
                     KIND_RESULT: begin
                        rsp_valid_ff <= 1'b1;
                        status_ff    <= cmd.status;
                     end
                     KIND_READ:  state_ff <= S_RDOUT;
                     KIND_CLEAR: begin
                        head_ff  <= '0;
                        fill_ff  <= '0;
                        clr_ff   <= '0;
                        reply_ff <= 1'b1;
                        state_ff <= S_CLR;
                     end
                     default:    state_ff <= S_SETUP;
                  endcase
               end
            end
            S_RDOUT: begin
               rsp_valid_ff <= 1'b1;
               status_ff    <= ST_OK;
               count_ff     <= rd_ok_ff ? hist_q_ff : 32'd0;
               state_ff     <= S_IDLE;
            end
            S_SETUP: begin
               edge_ff  <= 26'(cfg.width * nb);
               state_ff <= S_EV_RD;
            end
            S_EV_RD: begin
               // oldest entry first; empty window goes straight to insertion
               if (fill_ff == '0) state_ff <= S_DONE;
               else state_ff <= S_EV_TEST;
            end
            S_EV_TEST: begin
               if (lag2 > {15'd0, edge_ff}) begin
                  fill_ff  <= fill_ff - (WIN_AW+1)'(1);
                  state_ff <= S_EV_RD;
               end else if (fill_ff == (WIN_AW+1)'(WINDOW_DEPTH)) begin
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= ST_OVERFLOW;
                  state_ff     <= S_IDLE;
               end else begin
                  k_ff     <= '0;
                  state_ff <= S_W_RD;
               end
            end
            S_W_RD: state_ff <= S_W_LAG;
            S_W_LAG: begin
               dt2_ff    <= lag2[LAG_BITS-1:0];
               fwd_ok_ff <= lag2[LAG_BITS-1:0] < LAG_BITS'(edge_ff);
               rem_ff    <= lag2[LAG_BITS-1:0] + LAG_BITS'(cfg.width) - LAG_BITS'(1);
               b_ff      <= win_q_ff.unit;
               back_ff   <= 1'b1;
               quot_ff   <= '0;
               step_ff   <= 3'd4;
               state_ff  <= S_W_DIV;
            end
            S_W_DIV: begin
               // restoring division, one quotient bit a cycle
               if (rem_ff >= div_sh) begin
                  rem_ff           <= rem_ff - div_sh;
                  quot_ff[step_ff] <= 1'b1;
               end
               if (step_ff == 3'd0) state_ff <= S_W_IDX1;
               else step_ff <= step_ff - 3'd1;
            end
            S_W_IDX1: begin
               pair_ff  <= pair_sum[7:0];
               state_ff <= S_W_IDX2;
            end
            S_W_IDX2: begin
               haddr_ff <= idx_sum[HIST_AW-1:0];
               state_ff <= S_W_HRD;
            end
            S_W_HRD: state_ff <= S_W_HWR;
            S_W_HWR: begin
               added_ff <= added_ff + 8'd1;
               if (back_ff && fwd_ok_ff) begin
                  back_ff  <= 1'b0;
                  rem_ff   <= dt2_ff + LAG_BITS'(cfg.width);
                  quot_ff  <= '0;
                  step_ff  <= 3'd4;
                  state_ff <= S_W_DIV;
               end else if ((WIN_AW+1)'(k_ff) + (WIN_AW+1)'(1) == fill_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  k_ff     <= k_ff + WIN_AW'(1);
                  state_ff <= S_W_RD;
               end
            end
            S_DONE: begin
               head_ff      <= head_ff + WIN_AW'(1);
               fill_ff      <= fill_ff + (WIN_AW+1)'(1);
               rsp_valid_ff <= 1'b1;
               status_ff    <= ST_OK;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: hdl/spike_cross_correlogram_unit.sv
// top level of the spike cross-correlogram unit
//
// channel   direction  handshake            payload
// req_      in         push / full          func, spike_time, unit_id, read_index
// rsp_      out        empty / pop          status, bin_count, pairs_added
// csr_      in         valid / ready        index, wdata
//
// a spike's work grows with evictions and window fill, set by the serial window walk
//   with its five-step bin divider and histogram read-modify-write
// after reset and for every clear item all 16128 histogram entries are swept,
//   during which no new item is started (up to two wait in the command queue)
// the front end keeps accepting into the command queue while a result waits
`include "spike_cross_correlogram_unit_defines.svh"
module spike_cross_correlogram_unit import scc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_func,
   input  logic [TIME_BITS-1:0] req_spike_time,
   input  logic [7:0]           req_unit_id,
   input  logic [HIST_AW-1:0]   req_read_index,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_bin_count,
   output logic [7:0]           rsp_pairs_added,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [19:0]          csr_wdata
);
   cmd_type       push_cmd, pop_cmd;
   cfg_type       cfg;
   back_stat_type stat;
   logic          cmd_push, cmd_pop, cmd_valid, rsp_valid;

   // registers can always be written
   assign csr_ready = 1'b1;
   assign rsp_empty = !rsp_valid;

   // front end: checks unit id and time order, tracks last spike time
   scc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_spike_time (req_spike_time),
      .req_unit_id    (req_unit_id),
      .req_read_index (req_read_index),
      .csr_valid      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd_push       (cmd_push),
      .cmd_data       (push_cmd),
      .cfg            (cfg)
   );

   // decouples classification from the long histogram work
   scc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .pop_data  (pop_cmd)
   );

   // back end: window walk, binning, histogram, result register
   scc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd_valid       (cmd_valid),
      .cmd             (pop_cmd),
      .cmd_pop         (cmd_pop),
      .rsp_pop         (rsp_pop),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_pairs_added (rsp_pairs_added),
      .stat            (stat)
   );

   // no result is left over from before reset
   `SCC_ASSERT_NEXT(a_reset_empty, clock, reset, rsp_empty)
   // a histogram sweep never overlaps a pending result
   `SCC_ASSERT_IMPL(a_clear_no_rsp, clock, reset, stat.clearing, rsp_empty)
   // spike work only starts once the result register is free
   `SCC_ASSERT_IMPL(a_walk_no_rsp, clock, reset, stat.walking, rsp_empty)
   // back end never takes a command while sweeping
   `SCC_ASSERT_IMPL(a_no_pop_clear, clock, reset, stat.clearing, !cmd_pop)
endmodule

// File: bench/tb_spike_cross_correlogram_unit.sv
// self-checking testbench for the spike cross-correlogram unit
`timescale 1ns / 100ps
module tb_spike_cross_correlogram_unit;
   import scc_pkg::*;

   typedef struct {
      func_type              func;
      logic [TIME_BITS-1:0]  stamp;
      logic [7:0]            unit;
      logic [HIST_AW-1:0]    index;
   } spike_req_type;

   typedef struct {
      status_type  status;
      logic [31:0] count;
      logic [7:0]  pairs;
   } ccg_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [1:0]           req_func = '0;
   logic [TIME_BITS-1:0] req_spike_time = '0;
   logic [7:0]           req_unit_id = '0;
   logic [HIST_AW-1:0]   req_read_index = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [1:0]           rsp_status;
   logic [31:0]          rsp_bin_count;
   logic [7:0]           rsp_pairs_added;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = '0;
   logic [19:0]          csr_wdata = '0;

   spike_cross_correlogram_unit u_dut (.*);

   always #5 clock = ~clock;

   // correlogram predictor state
   logic [31:0]          hist_mirror [HIST_DEPTH];
   logic [TIME_BITS-1:0] ring_stamp [WINDOW_DEPTH];
   logic [3:0]           ring_unit [WINDOW_DEPTH];
   logic [WIN_AW-1:0]    ring_head = '0;
   int unsigned          ring_fill = 0;
   logic [TIME_BITS-1:0] newest_stamp = '0;
   logic [19:0]          cfg_width = 20'd1;
   logic [4:0]           cfg_half = 5'd0;
   logic [4:0]           cfg_units = 5'd16;

   spike_req_type  pending_reqs[$];
   ccg_answer_type expected_answers[$];
   int             mismatch_count = 0;
   int             csr_transfers = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             hold_cycles = 0;
   logic           req_taken = 1'b0;

   function automatic int unsigned eff_width();
      return (cfg_width == 0) ? 1 : cfg_width;
   endfunction

   function automatic int unsigned eff_units();
      if (cfg_units == 0) return 1;
      return (cfg_units > MAX_UNITS) ? MAX_UNITS : cfg_units;
   endfunction

   function automatic void bump_bin(int unsigned x, int unsigned y, int unsigned bin,
                                    int unsigned uc, int unsigned nb);
      longint unsigned idx;
      idx = (longint'(x) * uc + y) * nb + bin;
      if (idx < HIST_DEPTH && hist_mirror[idx] != 32'hFFFF_FFFF)
         hist_mirror[idx] = hist_mirror[idx] + 1;
   endfunction

   function automatic ccg_answer_type predict_answer(spike_req_type it);
      ccg_answer_type  ans;
      int unsigned     uc, w, h, nb, added, a, b, back, fwd;
      longint unsigned edge2, w2, dt, dt2;
      logic [WIN_AW-1:0] pos;
      ans = '{ST_OK, 32'd0, 8'd0};
      case (it.func)
         FUNC_READ: begin
            if (it.index < HIST_DEPTH) ans.count = hist_mirror[it.index];
         end
         FUNC_CLEAR: begin
            foreach (hist_mirror[i]) hist_mirror[i] = '0;
            ring_head = '0;
            ring_fill = 0;
            newest_stamp = '0;
         end
         FUNC_SPIKE: begin
            uc = eff_units();
            if (it.unit < 1 || it.unit > uc) ans.status = ST_BAD_UNIT;
            else if (it.stamp < newest_stamp) ans.status = ST_BACKWARD;
            else begin
               newest_stamp = it.stamp;
               w = eff_width();
               h = cfg_half;
               nb = 2 * h + 1;
               edge2 = longint'(w) * nb;
               w2 = 2 * longint'(w);
               // drop expired spikes, oldest first
               while (ring_fill > 0) begin
                  pos = WIN_AW'(ring_head - ring_fill);
                  dt = it.stamp - ring_stamp[pos];
                  if (dt > edge2 || 2 * dt > edge2) ring_fill--;
                  else break;
               end
               if (ring_fill >= WINDOW_DEPTH) ans.status = ST_OVERFLOW;
               else begin
                  added = 0;
                  a = it.unit - 1;
                  for (int k = 0; k < ring_fill; k++) begin
                     pos = WIN_AW'(ring_head - 1 - k);
                     dt2 = 2 * longint'(it.stamp - ring_stamp[pos]);
                     b = ring_unit[pos];
                     back = (dt2 + w - 1) / w2;
                     bump_bin(a, b, h - back, uc, nb);
                     added++;
                     if (dt2 < edge2) begin
                        fwd = (dt2 + w) / w2;
                        bump_bin(b, a, h + fwd, uc, nb);
                        added++;
                     end
                  end
                  ring_stamp[ring_head] = it.stamp;
                  ring_unit[ring_head] = 4'(a);
                  ring_head = ring_head + 1'b1;
                  ring_fill++;
                  ans.pairs = (added > 255) ? 8'd255 : 8'(added);
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      ccg_answer_type want;
      spike_req_type  seen;
      req_taken = req_push && !req_full && !reset;
      if (req_taken) begin
         seen.func = func_type'(req_func);
         seen.stamp = req_spike_time;
         seen.unit = req_unit_id;
         seen.index = req_read_index;
         expected_answers.push_back(predict_answer(seen));
      end
      if (csr_valid && csr_ready && !reset) begin
         case (csr_index_type'(csr_index))
            CSR_BIN_WIDTH:  cfg_width = csr_wdata;
            CSR_HALF_BINS:  cfg_half = csr_wdata[4:0];
            CSR_UNIT_COUNT: cfg_units = csr_wdata[4:0];
            default: ;
         endcase
         csr_transfers++;
      end
      if (rsp_pop && !rsp_empty && !reset) begin
         if (expected_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response transfer at %0t", $time);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_status !== want.status || rsp_bin_count !== want.count ||
                rsp_pairs_added !== want.pairs) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: exp st=%0d cnt=%0d pairs=%0d, got st=%0d cnt=%0d pairs=%0d",
                           $time, want.status, want.count, want.pairs,
                           rsp_status, rsp_bin_count, rsp_pairs_added);
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock)
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

   // driver: requests and pops change on the falling edge
   always @(negedge clock) begin
      spike_req_type it;
      if (!req_push || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_reqs.pop_front();
            req_func <= it.func;
            req_spike_time <= it.stamp;
            req_unit_id <= it.unit;
            req_read_index <= it.index;
            req_push <= 1'b1;
         end else
            req_push <= 1'b0;
      end
      rsp_pop <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(csr_index_type idx, int unsigned value);
      int start;
      start = csr_transfers;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 20'(value);
      do @(negedge clock); while (csr_transfers == start);
      csr_valid <= 1'b0;
   endtask

   // idle means nothing queued, nothing offered and no response still owed
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_push || expected_answers.size() > 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic add_req(func_type f, longint unsigned t, int unsigned u, int unsigned idx);
      spike_req_type it;
      it.func = f;
      it.stamp = TIME_BITS'(t);
      it.unit = 8'(u);
      it.index = HIST_AW'(idx);
      pending_reqs.push_back(it);
   endtask

   // random traffic, mostly ordered spike trains under the current settings
   task automatic gen_traffic(int count, ref int clears_left, ref longint unsigned cur_t);
      int unsigned w, h, uc, nb, r, burst;
      longint unsigned span;
      w = eff_width();
      h = cfg_half;
      uc = eff_units();
      nb = 2 * h + 1;
      span = 3 * longint'(w) * (h + 1);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 58) begin
            cur_t += (span > 32'hFFFF_FFFF) ? $urandom : $urandom_range(0, 32'(span));
            add_req(FUNC_SPIKE, cur_t, $urandom_range(1, uc), $urandom);
         end else if (r < 74) begin
            add_req(FUNC_READ, $urandom, $urandom,
                    (($urandom_range(0, uc - 1) * uc + $urandom_range(0, uc - 1)) * nb
                     + $urandom_range(0, nb - 1)));
         end else if (r < 78) begin
            add_req(FUNC_READ, $urandom, $urandom, $urandom_range(0, 16383));
         end else if (r < 83) begin
            // unit id of zero or beyond the count
            add_req(FUNC_SPIKE, cur_t, ($urandom_range(1)) ? 0 : $urandom_range(uc + 1, 255),
                    $urandom);
         end else if (r < 87) begin
            if (cur_t > 0) add_req(FUNC_SPIKE, cur_t - $urandom_range(1, 1000) % cur_t - 1 + 1
                                   - (cur_t > 1000 ? 0 : 0), $urandom_range(1, uc), $urandom);
         end else if (r < 89) begin
            add_req(FUNC_NONE, {$urandom, $urandom}, $urandom, $urandom);
         end else if (r < 94) begin
            // equal-time burst
            burst = $urandom_range(4, 12);
            cur_t += $urandom_range(0, 3);
            repeat (burst) add_req(FUNC_SPIKE, cur_t, $urandom_range(1, uc), $urandom);
         end else if (r < 95 && clears_left > 0) begin
            clears_left--;
            add_req(FUNC_CLEAR, {$urandom, $urandom}, $urandom, $urandom);
            cur_t = {$urandom, $urandom} % ((64'd1 << TIME_BITS) - (64'd1 << 36));
         end else begin
            cur_t += $urandom_range(0, 1 << 24);
            add_req(FUNC_SPIKE, cur_t, $urandom_range(1, uc), $urandom);
         end
      end
   endtask

   initial begin
      int clears_left;
      longint unsigned cur_t;
      foreach (hist_mirror[i]) hist_mirror[i] = '0;
      clears_left = 7;
      cur_t = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, zero-lag pairs, bad ids, backward time, edge reads
      send_idle_pct = 16;
      recv_idle_pct = 48;
      add_req(FUNC_SPIKE, 0, 1, 0);
      add_req(FUNC_SPIKE, 0, 16, 0);
      add_req(FUNC_SPIKE, 1, 2, 0);
      add_req(FUNC_SPIKE, 1, 0, 0);
      add_req(FUNC_SPIKE, 1, 17, 0);
      add_req(FUNC_SPIKE, 2, 255, 0);
      add_req(FUNC_SPIKE, 0, 3, 0);
      add_req(FUNC_NONE, 64'hFF_FFFF_FFFF, 255, 16383);
      add_req(FUNC_READ, 0, 0, 0);
      add_req(FUNC_READ, 0, 0, 15);
      add_req(FUNC_READ, 0, 0, 240);
      add_req(FUNC_READ, 0, 0, 16127);
      add_req(FUNC_READ, 0, 0, 16128);
      add_req(FUNC_READ, 0, 0, 16383);
      add_req(FUNC_CLEAR, 0, 0, 0);
      add_req(FUNC_READ, 0, 0, 15);
      add_req(FUNC_SPIKE, 64'hFF_FFFF_FFFF, 16, 0);
      add_req(FUNC_SPIKE, 64'hFF_FFFF_FFFF, 16, 0);
      add_req(FUNC_READ, 0, 0, 255);
      add_req(FUNC_SPIKE, 64'hFF_FFFF_FFFE, 1, 0);
      add_req(FUNC_CLEAR, 0, 0, 0);
      gen_traffic(80, clears_left, cur_t);
      wait_idle();

      // widest bins, single unit: long windows and overflow
      write_reg(CSR_BIN_WIDTH, 20'hFFFFF);
      write_reg(CSR_HALF_BINS, 31);
      write_reg(CSR_UNIT_COUNT, 1);
      cur_t += 1;
      repeat (70) add_req(FUNC_SPIKE, cur_t, 1, 0);
      add_req(FUNC_READ, 0, 0, 31);
      gen_traffic(40, clears_left, cur_t);
      wait_idle();

      // zero width acts as one
      send_idle_pct = 48;
      recv_idle_pct = 16;
      write_reg(CSR_BIN_WIDTH, 0);
      write_reg(CSR_UNIT_COUNT, 16);
      gen_traffic(100, clears_left, cur_t);
      wait_idle();

      // unit count of zero acts as one
      write_reg(CSR_BIN_WIDTH, 3);
      write_reg(CSR_HALF_BINS, 2);
      write_reg(CSR_UNIT_COUNT, 0);
      gen_traffic(100, clears_left, cur_t);
      wait_idle();

      // unit count above the maximum, with a long receiver stall
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_BIN_WIDTH, 7);
      write_reg(CSR_HALF_BINS, 5);
      write_reg(CSR_UNIT_COUNT, 31);
      gen_traffic(100, clears_left, cur_t);
      hold_cycles = 4000;
      wait_idle();

      write_reg(CSR_BIN_WIDTH, 100);
      write_reg(CSR_HALF_BINS, 7);
      write_reg(CSR_UNIT_COUNT, 5);
      gen_traffic(100, clears_left, cur_t);
      wait_idle();

      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(64'd200_000_000);
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hdl
hdl/scc_pkg.sv
hdl/scc_front.sv
hdl/scc_queue.sv
hdl/scc_back.sv
hdl/spike_cross_correlogram_unit.sv
bench/tb_spike_cross_correlogram_unit.sv
